// ===== hdl/bprf_pkg.sv =====
// Shared types, sizes and codes of the byte pipe ring FIFO.
`default_nettype none

package bprf_pkg;

  localparam int unsigned RING_DEPTH = 4096;
  localparam int unsigned PTR_W      = $clog2(RING_DEPTH);
  localparam int unsigned MAX_BURST  = 64;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned STAT_W     = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_PEEK  = 2'd2,
    CMD_CLOSE = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 3'd0,
    ST_WOULD_BLOCK = 3'd1,
    ST_END         = 3'd2,
    ST_FULL        = 3'd3,
    ST_CLOSED      = 3'd4,
    ST_ALREADY     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_FETCH = 2'd1,
    S_SEND  = 2'd2
  } state_e;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [PTR_W-1:0]  addr;
    logic [BYTE_W-1:0] wdata;
  } ram_req_t;

endpackage

`default_nettype wire

// ===== hdl/bprf_if.sv =====
// Valid/ready channels for command beats and result beats.
`default_nettype none

interface bprf_in_if;
  logic                           valid;
  logic                           ready;
  logic [bprf_pkg::CMD_W-1:0]     cmd;
  logic [bprf_pkg::BYTE_W-1:0]    data_in;
  logic [bprf_pkg::LEN_W-1:0]     req_length;

  modport source (output valid, cmd, data_in, req_length, input ready);
  modport sink   (input valid, cmd, data_in, req_length, output ready);
endinterface

interface bprf_out_if;
  logic                           valid;
  logic                           ready;
  logic [bprf_pkg::BYTE_W-1:0]    data_out;
  logic [bprf_pkg::LEN_W-1:0]     count;
  logic                           last;
  logic [bprf_pkg::STAT_W-1:0]    status;

  modport source (output valid, data_out, count, last, status, input ready);
  modport sink   (input valid, data_out, count, last, status, output ready);
endinterface

`default_nettype wire

// ===== hdl/bprf_ram.sv =====
// Ring storage: one shared port, registered read data.
`default_nettype none

module bprf_ram (
  input  wire logic                        clk_i,
  input  wire bprf_pkg::ram_req_t          req_i,
  output logic [bprf_pkg::BYTE_W-1:0]      rdata_o
);

  logic [bprf_pkg::BYTE_W-1:0] mem_q [bprf_pkg::RING_DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_o <= mem_q[req_i.addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bprf_ctrl.sv =====
// Command sequencer: pointers, flags, burst stepping and the result register.
`default_nettype none

module bprf_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  bprf_in_if.sink                          in_s,
  bprf_out_if.source                       out_s,
  output bprf_pkg::ram_req_t               ram_req_o,
  input  wire logic [bprf_pkg::BYTE_W-1:0] ram_rdata_i
);

  localparam int unsigned PW = bprf_pkg::PTR_W;
  localparam int unsigned LW = bprf_pkg::LEN_W;
  localparam int unsigned BW = bprf_pkg::BYTE_W;

  bprf_pkg::state_e state_q, state_d;

  logic [PW-1:0] rp_q, rp_d, wp_q, wp_d, ptr_q, ptr_d;
  logic          full_q, full_d, closed_q, closed_d;
  logic          is_read_q, is_read_d;
  logic [LW-1:0] len_q, len_d, idx_q, idx_d;

  logic                     out_valid_q, out_valid_d;
  logic [BW-1:0]            data_q, data_d;
  logic [LW-1:0]            count_q, count_d;
  logic                     last_q, last_d;
  bprf_pkg::status_e        status_q, status_d;

  bprf_pkg::cmd_e  cmd;
  logic            slot_free, accept, empty, is_xfer, burst_go, send, send_last;
  logic [PW:0]     avail;
  logic [LW-1:0]   req_clip, burst_len, idx_inc;
  logic [PW-1:0]   step_in, step_out;

  assign cmd       = bprf_pkg::cmd_e'(in_s.cmd);
  assign slot_free = !out_valid_q || out_s.ready;
  assign in_s.ready = (state_q == bprf_pkg::S_IDLE) && slot_free;
  assign accept    = in_s.valid && in_s.ready;

  // Shared pointer step: write pointer while idle, burst address otherwise.
  assign step_in  = (state_q == bprf_pkg::S_IDLE) ? wp_q : ptr_q;
  assign step_out = step_in + PW'(1);

  assign empty   = !full_q && (wp_q == rp_q);
  assign avail   = full_q ? (PW+1)'(bprf_pkg::RING_DEPTH) : {1'b0, wp_q - rp_q};
  assign is_xfer = (cmd == bprf_pkg::CMD_READ) || (cmd == bprf_pkg::CMD_PEEK);

  always_comb begin
    req_clip = (32'(in_s.req_length) > bprf_pkg::MAX_BURST) ?
               LW'(bprf_pkg::MAX_BURST) : in_s.req_length;
    if (32'(req_clip) > 32'(avail)) begin
      burst_len = LW'(avail);
    end else begin
      burst_len = req_clip;
    end
  end

  assign burst_go  = accept && is_xfer && !empty && (burst_len != '0);
  assign idx_inc   = idx_q + LW'(1);
  assign send      = (state_q == bprf_pkg::S_SEND) && slot_free;
  assign send_last = send && (idx_inc == len_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bprf_pkg::S_IDLE:  if (burst_go) state_d = bprf_pkg::S_FETCH;
      bprf_pkg::S_FETCH: state_d = bprf_pkg::S_SEND;
      bprf_pkg::S_SEND: begin
        if (send_last) begin
          state_d = bprf_pkg::S_IDLE;
        end else if (send) begin
          state_d = bprf_pkg::S_FETCH;
        end
      end
      default: state_d = bprf_pkg::S_IDLE;
    endcase
  end

  // Datapath and result register.
  always_comb begin
    rp_d        = rp_q;
    wp_d        = wp_q;
    full_d      = full_q;
    closed_d    = closed_q;
    ptr_d       = ptr_q;
    is_read_d   = is_read_q;
    len_d       = len_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_s.ready;
    data_d      = data_q;
    count_d     = count_q;
    last_d      = last_q;
    status_d    = status_q;
    ram_req_o   = '{we: 1'b0, re: 1'b0, addr: ptr_q, wdata: in_s.data_in};

    unique case (state_q)
      bprf_pkg::S_IDLE: begin
        ram_req_o.addr = wp_q;
        if (accept && !burst_go) begin
          out_valid_d = 1'b1;
          data_d      = '0;
          count_d     = '0;
          last_d      = 1'b1;
          status_d    = bprf_pkg::ST_OK;
          unique case (cmd)
            bprf_pkg::CMD_WRITE: begin
              if (closed_q) begin
                status_d = bprf_pkg::ST_CLOSED;
              end else if (full_q) begin
                status_d = bprf_pkg::ST_FULL;
              end else begin
                ram_req_o.we = 1'b1;
                wp_d         = step_out;
                full_d       = (step_out == rp_q);
                count_d      = LW'(1);
              end
            end
            bprf_pkg::CMD_CLOSE: begin
              closed_d = 1'b1;
              if (closed_q) status_d = bprf_pkg::ST_ALREADY;
            end
            default: begin
              // Empty pipe or zero-length request: single empty result.
              if (empty) begin
                status_d = closed_q ? bprf_pkg::ST_END : bprf_pkg::ST_WOULD_BLOCK;
              end
            end
          endcase
        end
        if (burst_go) begin
          ptr_d     = rp_q;
          len_d     = burst_len;
          idx_d     = '0;
          is_read_d = (cmd == bprf_pkg::CMD_READ);
        end
      end
      bprf_pkg::S_FETCH: begin
        ram_req_o.re = 1'b1;
      end
      bprf_pkg::S_SEND: begin
        if (send) begin
          out_valid_d = 1'b1;
          data_d      = ram_rdata_i;
          count_d     = len_q;
          last_d      = send_last;
          status_d    = bprf_pkg::ST_OK;
          ptr_d       = step_out;
          idx_d       = idx_inc;
          if (send_last && is_read_q) begin
            rp_d   = step_out;
            full_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bprf_pkg::S_IDLE;
      rp_q        <= '0;
      wp_q        <= '0;
      full_q      <= 1'b0;
      closed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rp_q        <= rp_d;
      wp_q        <= wp_d;
      full_q      <= full_d;
      closed_q    <= closed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    is_read_q <= is_read_d;
    len_q     <= len_d;
    idx_q     <= idx_d;
    data_q    <= data_d;
    count_q   <= count_d;
    last_q    <= last_d;
    status_q  <= status_d;
  end

  assign out_s.valid    = out_valid_q;
  assign out_s.data_out = data_q;
  assign out_s.count    = count_q;
  assign out_s.last     = last_q;
  assign out_s.status   = status_q;

endmodule

`default_nettype wire

// ===== hdl/byte_pipe_ring_fifo.sv =====
// Byte pipe over a ring buffer: top level.
// A write, close, empty or zero-length beat shows its result in the cycle after it is
// taken; a burst moves each byte through the fetch and send states and the result
// register. Single-result beats are taken one per cycle while the output is not stalled;
// a burst holds the input until its last byte is sent (single RAM port: address, data).
// Reset: asynchronous, active low; pointers, full and closed flags clear, RAM is not swept.
`default_nettype none

module byte_pipe_ring_fifo (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  bprf_in_if.sink     in_i,
  bprf_out_if.source  out_o
);

  bprf_pkg::ram_req_t          ram_req;
  logic [bprf_pkg::BYTE_W-1:0] ram_rdata;

  // Sequencer: decodes command beats, owns pointers and flags, and steps
  // bursts one byte at a time through the shared pointer incrementer.
  bprf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_s        (in_i),
    .out_s       (out_o),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  // Ring storage: written at the write pointer, read at the burst address.
  bprf_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

// ===== hdl/bprf_checker.sv =====
// Port-level checks on result beats, bound to the top level.
`default_nettype none

module bprf_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [bprf_pkg::BYTE_W-1:0]       out_data,
  input wire logic [bprf_pkg::LEN_W-1:0]        out_count,
  input wire logic                              out_last,
  input wire logic [bprf_pkg::STAT_W-1:0]       out_status
);

  // Hold a stalled result beat.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data) &&
      $stable(out_count) && $stable(out_last) && $stable(out_status))
    else $error("stalled result beat changed");

  // A non-final beat belongs to a successful burst of two or more bytes.
  a_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_last |-> out_status == bprf_pkg::ST_OK && out_count > 7'd1)
    else $error("non-final beat outside a burst");

  // An error status carries no byte and ends the request.
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_status != bprf_pkg::ST_OK |-> out_count == '0 &&
      out_data == '0 && out_last)
    else $error("error beat carries data");

  // A zero count carries no byte and is the only beat.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_count == '0 |-> out_data == '0 && out_last)
    else $error("empty beat carries data");

  a_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> 32'(out_count) <= bprf_pkg::MAX_BURST)
    else $error("burst count above limit");

endmodule

bind byte_pipe_ring_fifo bprf_checker u_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .out_data   (out_o.data_out),
  .out_count  (out_o.count),
  .out_last   (out_o.last),
  .out_status (out_o.status)
);

`default_nettype wire
